>>> hw/rtl/gww_pkg.sv
package gww_pkg;

    // configuration register width, fixed by the register map
    localparam int unsigned C_CFG_W = 6;
    // width of pointer and count fields carried between front and back;
    // covers the full range of the line length parameter
    localparam int unsigned C_FLD_W = 6;
    localparam int unsigned C_Q_DEPTH = 4;
    localparam int unsigned C_Q_PW = $clog2(C_Q_DEPTH);

    localparam logic [C_CFG_W-1:0] C_LL_RESET = 6'd17;

    localparam logic [7:0] C_SEP = 8'h20;
    localparam logic [7:0] C_NL  = 8'h0A;
    localparam logic [7:0] C_NUL = 8'h00;

    // one output run: optional new line, count characters from start, optional space
    typedef struct packed {
        logic               nl;
        logic               sp;
        logic [C_FLD_W-1:0] start;
        logic [C_FLD_W-1:0] count;
    } t_cmd;

    // word store write port
    typedef struct packed {
        logic               en;
        logic [C_FLD_W-1:0] addr;
        logic [7:0]         data;
    } t_wr;

    typedef enum logic [1:0] {
        S_IDLE,
        S_NL,
        S_CHR,
        S_SP
    } t_bstate;

    typedef enum logic [1:0] {
        K_CHR,
        K_NL,
        K_SP
    } t_kind;

endpackage

>>> hw/rtl/gww_cmd_fifo.sv
module gww_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gww_pkg::t_cmd i_data,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output gww_pkg::t_cmd o_data
);

    gww_pkg::t_cmd r_mem [gww_pkg::C_Q_DEPTH];
    logic [gww_pkg::C_Q_PW-1:0] r_wp;
    logic [gww_pkg::C_Q_PW-1:0] r_rp;
    logic [gww_pkg::C_Q_PW:0]   r_cnt;
    logic w_push;
    logic w_pop;

    assign o_ready = (r_cnt != (gww_pkg::C_Q_PW+1)'(gww_pkg::C_Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> hw/rtl/gww_front.sv
module gww_front #(
    parameter int unsigned MAX_LINE = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [gww_pkg::C_CFG_W-1:0] i_cfg_data,
    input  logic                        i_valid,
    input  logic [7:0]                  i_char,
    input  logic                        i_end,
    output logic                        o_ready,
    input  logic                        i_q_ready,
    input  logic                        i_free,
    output logic                        o_cmd_valid,
    output gww_pkg::t_cmd               o_cmd,
    output gww_pkg::t_wr                o_wr
);

    localparam int unsigned DEPTH = MAX_LINE + 1;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CW    = $clog2(MAX_LINE + 2);
    localparam int unsigned UW    = $clog2(DEPTH + 1);

    function automatic logic [CW-1:0] eff_len(input logic [gww_pkg::C_CFG_W-1:0] ll);
        logic [CW-1:0] n;
        if (ll == '0) begin
            n = CW'(1);
        end else if ({1'b0, ll} > (gww_pkg::C_CFG_W+1)'(MAX_LINE)) begin
            n = CW'(MAX_LINE);
        end else begin
            n = CW'(ll);
        end
        return n;
    endfunction

    logic [gww_pkg::C_CFG_W-1:0] r_line_len;
    logic [CW-1:0] r_wc,   n_wc;
    logic [CW-1:0] r_cl,   n_cl;
    logic [AW-1:0] r_tail, n_tail;
    logic [UW-1:0] r_used;

    logic [CW-1:0] w_n;
    logic          w_accept;
    logic [AW:0]   w_diff;
    logic [AW-1:0] w_start;
    logic          w_nl;
    logic [CW-1:0] w_cl1;
    logic [CW-1:0] w_cl2;

    assign w_n      = eff_len(r_line_len);
    assign o_ready  = i_q_ready && (r_used < UW'(DEPTH));
    assign w_accept = i_valid && o_ready;

    // first store entry of the pending word, modulo the store depth
    assign w_diff  = {1'b0, r_tail} - (AW+1)'(r_wc);
    assign w_start = w_diff[AW] ? AW'(w_diff + (AW+1)'(DEPTH)) : w_diff[AW-1:0];

    always_comb begin
        n_wc        = r_wc;
        n_cl        = r_cl;
        n_tail      = r_tail;
        o_cmd_valid = 1'b0;
        o_cmd       = '0;
        o_wr        = '0;
        w_nl        = 1'b0;
        w_cl1       = r_cl;
        w_cl2       = r_cl;
        if (w_accept) begin
            if (i_end || (i_char == gww_pkg::C_SEP)) begin
                if (r_wc != '0) begin
                    // word ends: new line if it does not fit, space if room remains
                    w_nl        = (r_wc > r_cl) || (r_cl == '0);
                    w_cl1       = w_nl ? w_n : r_cl;
                    w_cl2       = w_cl1 - r_wc;
                    o_cmd_valid = 1'b1;
                    o_cmd.nl    = w_nl;
                    o_cmd.sp    = (w_cl2 != '0);
                    o_cmd.start = gww_pkg::C_FLD_W'(w_start);
                    o_cmd.count = gww_pkg::C_FLD_W'(r_wc);
                    n_cl        = (w_cl2 != '0) ? (w_cl2 - 1'b1) : w_cl2;
                    n_wc        = '0;
                end
                if (i_end) begin
                    n_cl = w_n;
                end
            end else if (i_char != gww_pkg::C_NUL) begin
                o_wr.en   = 1'b1;
                o_wr.addr = gww_pkg::C_FLD_W'(r_tail);
                o_wr.data = i_char;
                n_tail    = (r_tail == AW'(DEPTH - 1)) ? '0 : (r_tail + 1'b1);
                if (r_wc == w_n) begin
                    // word longer than a line: fill the rest of the line
                    w_nl        = (r_cl == '0);
                    w_cl1       = w_nl ? w_n : r_cl;
                    o_cmd_valid = 1'b1;
                    o_cmd.nl    = w_nl;
                    o_cmd.sp    = 1'b0;
                    o_cmd.start = gww_pkg::C_FLD_W'(w_start);
                    o_cmd.count = gww_pkg::C_FLD_W'(w_cl1);
                    n_wc        = r_wc + 1'b1 - w_cl1;
                    n_cl        = '0;
                end else begin
                    n_wc = r_wc + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_len <= gww_pkg::C_LL_RESET;
            r_wc       <= '0;
            r_cl       <= eff_len(gww_pkg::C_LL_RESET);
            r_tail     <= '0;
            r_used     <= '0;
        end else if (i_cfg_valid) begin
            // drop the pending word, reload the line
            r_line_len <= i_cfg_data;
            r_wc       <= '0;
            r_cl       <= eff_len(i_cfg_data);
            r_used     <= '0;
        end else begin
            r_wc   <= n_wc;
            r_cl   <= n_cl;
            r_tail <= n_tail;
            unique case ({o_wr.en, i_free})
                2'b10:   r_used <= r_used + 1'b1;
                2'b01:   r_used <= r_used - 1'b1;
                default: r_used <= r_used;
            endcase
        end
    end

endmodule

>>> hw/rtl/gww_back.sv
module gww_back #(
    parameter int unsigned MAX_LINE = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gww_pkg::t_wr  i_wr,
    input  logic          i_cmd_valid,
    input  gww_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_free,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [7:0]    o_m_char,
    output logic          o_m_last
);

    localparam int unsigned DEPTH = MAX_LINE + 1;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CW    = $clog2(MAX_LINE + 2);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    gww_pkg::t_bstate r_state, n_state;
    logic [AW-1:0]    r_addr,  n_addr;
    logic [CW-1:0]    r_left,  n_left;
    logic             r_sp,    n_sp;

    logic             r_s1_valid;
    gww_pkg::t_kind   r_s1_kind;
    logic             r_s1_last;

    logic             r_out_valid;
    logic [7:0]       r_out_char;
    logic             r_out_last;

    logic             w_out_free;
    logic             w_issue_ok;
    logic             w_tok_v;
    gww_pkg::t_kind   w_tok_kind;
    logic             w_tok_last;
    logic             w_rd_en;
    logic [7:0]       w_s1_char;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_issue_ok = !r_s1_valid || w_out_free;
    assign o_free     = w_rd_en;
    assign o_m_tvalid = r_out_valid;
    assign o_m_char   = r_out_char;
    assign o_m_last   = r_out_last;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[AW'(i_wr.addr)] <= i_wr.data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_left     = r_left;
        n_sp       = r_sp;
        o_cmd_pop  = 1'b0;
        w_tok_v    = 1'b0;
        w_tok_kind = gww_pkg::K_CHR;
        w_tok_last = 1'b0;
        w_rd_en    = 1'b0;
        unique case (r_state)
            gww_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_addr    = AW'(i_cmd.start);
                    n_left    = CW'(i_cmd.count);
                    n_sp      = i_cmd.sp;
                    n_state   = i_cmd.nl ? gww_pkg::S_NL : gww_pkg::S_CHR;
                end
            end
            gww_pkg::S_NL: begin
                if (w_issue_ok) begin
                    w_tok_v    = 1'b1;
                    w_tok_kind = gww_pkg::K_NL;
                    n_state    = gww_pkg::S_CHR;
                end
            end
            gww_pkg::S_CHR: begin
                if (w_issue_ok) begin
                    w_tok_v    = 1'b1;
                    w_tok_kind = gww_pkg::K_CHR;
                    w_tok_last = (r_left == CW'(1)) && !r_sp;
                    w_rd_en    = 1'b1;
                    n_addr     = (r_addr == AW'(DEPTH - 1)) ? '0 : (r_addr + 1'b1);
                    n_left     = r_left - 1'b1;
                    if (r_left == CW'(1)) begin
                        n_state = r_sp ? gww_pkg::S_SP : gww_pkg::S_IDLE;
                    end
                end
            end
            gww_pkg::S_SP: begin
                if (w_issue_ok) begin
                    w_tok_v    = 1'b1;
                    w_tok_kind = gww_pkg::K_SP;
                    w_tok_last = 1'b1;
                    n_state    = gww_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gww_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        unique case (r_s1_kind)
            gww_pkg::K_NL: w_s1_char = gww_pkg::C_NL;
            gww_pkg::K_SP: w_s1_char = gww_pkg::C_SEP;
            default:       w_s1_char = r_rd_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gww_pkg::S_IDLE;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_issue_ok) begin
                r_s1_valid <= w_tok_v;
            end
            if (w_out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_left <= n_left;
        r_sp   <= n_sp;
        if (w_issue_ok) begin
            r_s1_kind <= w_tok_kind;
            r_s1_last <= w_tok_last;
        end
        // hold the result while the receiver stalls
        if (w_out_free) begin
            r_out_char <= w_s1_char;
            r_out_last <= r_s1_last;
        end
    end

endmodule

>>> hw/rtl/greedy_word_wrap.sv
// Greedy word wrap of a character stream.
// Input stream: one text byte per transaction in tdata; tuser set means end of
// text (tdata ignored): the pending word is flushed and the line count reloads.
// Spaces separate words and runs of them collapse; a zero byte is dropped.
// Output stream: wrapped bytes (word characters, space, new line) in tdata;
// tlast marks the last byte caused by one input transaction. Inputs that cause
// no output give no output transaction.
// Config channel: writes the line length (0 acts as 1, above MAX_LINE acts as
// MAX_LINE), drops any pending word and starts a fresh line. Write only idle.
// Throughput: the front takes one input per cycle while its 4-entry run queue
// and the word store have room; the back emits one byte per cycle while the
// receiver takes them, and pops each run in its idle state before its bytes.
// A run's first byte passes the queue, back state, token and output registers.
// Reset: line length 17, no pending word, full line available.
// Receiver stall: the output register holds; the back pauses, the queue fills,
// then the input stalls by dropping tready.
module greedy_word_wrap #(
    parameter int unsigned MAX_LINE = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [7:0]                  i_s_tdata,   // [7:0] text_char
    input  logic                        i_s_tuser,   // [0] end_of_text
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [gww_pkg::C_CFG_W-1:0] i_cfg_data,  // line_length
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [7:0]                  o_m_tdata,   // [7:0] out_char
    output logic                        o_m_tlast    // run_last
);

    gww_pkg::t_cmd w_cmd_in;
    gww_pkg::t_cmd w_cmd_out;
    gww_pkg::t_wr  w_wr;
    logic          w_cmd_push;
    logic          w_q_ready;
    logic          w_q_valid;
    logic          w_q_pop;
    logic          w_free;

    assign o_cfg_ready = 1'b1;

    gww_front #(
        .MAX_LINE(MAX_LINE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_tvalid),
        .i_char      (i_s_tdata),
        .i_end       (i_s_tuser),
        .o_ready     (o_s_tready),
        .i_q_ready   (w_q_ready),
        .i_free      (w_free),
        .o_cmd_valid (w_cmd_push),
        .o_cmd       (w_cmd_in),
        .o_wr        (w_wr)
    );

    gww_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_cmd_in),
        .o_ready (w_q_ready),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_cmd_out)
    );

    gww_back #(
        .MAX_LINE(MAX_LINE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (w_wr),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_cmd_out),
        .o_cmd_pop   (w_q_pop),
        .o_free      (w_free),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_char    (o_m_tdata),
        .o_m_last    (o_m_tlast)
    );

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int LINE_MAX   = 32;
    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE_CYC = 16;
    localparam int PHASE_LEN  = 50;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_beat;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_s_tvalid  = 1'b0;
    logic [7:0]                  i_s_tdata   = 8'h00;
    logic                        i_s_tuser   = 1'b0;
    logic                        i_cfg_valid = 1'b0;
    logic [gww_pkg::C_CFG_W-1:0] i_cfg_data  = '0;
    logic                        i_m_tready  = 1'b0;
    logic                        o_s_tready;
    logic                        o_cfg_ready;
    logic                        o_m_tvalid;
    logic [7:0]                  o_m_tdata;
    logic                        o_m_tlast;

    // wrap state as the block should hold it
    logic [gww_pkg::C_CFG_W-1:0] line_len_reg;
    logic [7:0]                  word_buf [0:LINE_MAX];
    int                          word_fill;
    int                          cols_left;

    t_beat wrap_expect_q [$];
    t_beat item_out_q [$];

    int  err_cnt     = 0;
    int  beat_idx    = 0;
    int  text_items  = 0;
    int  stall_left  = 0;
    int  idle_cyc    = 0;
    bit  tx_gaps_on  = 1'b1;
    bit  rx_stalls_on = 1'b1;

    greedy_word_wrap #(
        .MAX_LINE(LINE_MAX)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),   // [7:0] text_char
        .i_s_tuser   (i_s_tuser),   // [0] end_of_text
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),  // line_length
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),   // [7:0] out_char
        .o_m_tlast   (o_m_tlast)    // run_last
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ---------------- wrap predictor ----------------

    function automatic int line_width();
        int n;
        n = int'(line_len_reg);
        if (n < 1) n = 1;
        if (n > LINE_MAX) n = LINE_MAX;
        return n;
    endfunction

    function automatic void put_char(logic [7:0] ch);
        t_beat b;
        b.ch   = ch;
        b.last = 1'b0;
        item_out_q.push_back(b);
    endfunction

    function automatic void load_line_length(logic [gww_pkg::C_CFG_W-1:0] v);
        line_len_reg = v;
        word_fill    = 0;
        cols_left    = line_width();
    endfunction

    function automatic void flush_word(int n);
        int w;
        if (word_fill == 0) return;
        w = (word_fill > n) ? n : word_fill;
        if (w > cols_left || cols_left == 0) begin
            put_char(gww_pkg::C_NL);
            cols_left = n;
        end
        for (int i = 0; i < w; i++) put_char(word_buf[i]);
        cols_left -= w;
        if (cols_left > 0) begin
            put_char(gww_pkg::C_SEP);
            cols_left--;
        end
        word_fill = 0;
    endfunction

    // word is longer than a line: fill what is left and keep the tail
    function automatic void flush_chunk(int n);
        int take;
        if (cols_left == 0) begin
            put_char(gww_pkg::C_NL);
            cols_left = n;
        end
        take = (cols_left > word_fill) ? word_fill : cols_left;
        for (int i = 0; i < take; i++) put_char(word_buf[i]);
        for (int i = 0; i < word_fill - take; i++) word_buf[i] = word_buf[i + take];
        word_fill -= take;
        cols_left -= take;
    endfunction

    function automatic void wrap_predict(logic [7:0] ch, logic eot);
        int n;
        n = line_width();
        item_out_q.delete();
        if (cols_left > n) cols_left = n;
        if (eot) begin
            flush_word(n);
            cols_left = n;
        end else if (ch == gww_pkg::C_SEP) begin
            flush_word(n);
        end else if (ch != gww_pkg::C_NUL) begin
            if (word_fill <= LINE_MAX) begin
                word_buf[word_fill] = ch;
                word_fill++;
            end
            if (word_fill > n) flush_chunk(n);
        end
        if (item_out_q.size() > 0) item_out_q[item_out_q.size() - 1].last = 1'b1;
        foreach (item_out_q[i]) wrap_expect_q.push_back(item_out_q[i]);
    endfunction

    // ---------------- idle lengths ----------------

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ---------------- output side: check and stall ----------------

    always @(posedge i_clk) begin : out_side
        t_beat got;
        t_beat want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.ch   = o_m_tdata;
            got.last = o_m_tlast;
            if (wrap_expect_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("output %0d: nothing expected, got byte %h last %b",
                             beat_idx, got.ch, got.last);
            end else begin
                want = wrap_expect_q.pop_front();
                if (got.ch !== want.ch || got.last !== want.last) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("output %0d: expected byte %h last %b, got byte %h last %b",
                                 beat_idx, want.ch, want.last, got.ch, got.last);
                end
            end
            beat_idx++;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else if (rx_stalls_on && $urandom_range(0, 4) == 0) begin
            stall_left = idle_len() - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // abort when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cyc <= 0;
        end else if (idle_cyc >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cyc <= idle_cyc + 1;
        end
    end

    // ---------------- input side ----------------

    // leaves tvalid high after the transaction so back-to-back items need no gap
    task automatic send_item(input logic [7:0] ch, input logic eot);
        int gap;
        gap = (tx_gaps_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= ch;
        i_s_tuser  <= eot;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        wrap_predict(ch, eot);
        if (eot || ch != gww_pkg::C_NUL) text_items++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    endtask

    task automatic send_end();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // hold input low until every expected byte is out, then let the block settle
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (wrap_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_line_length(input logic [gww_pkg::C_CFG_W-1:0] v);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        load_line_length(v);
    endtask

    function automatic logic [7:0] rand_word_char();
        logic [7:0] c;
        if ($urandom_range(0, 9) < 7) return 8'h61 + 8'($urandom_range(0, 25));
        do c = 8'($urandom_range(1, 255)); while (c == gww_pkg::C_SEP);
        return c;
    endfunction

    task automatic send_word(input int len);
        for (int i = 0; i < len; i++) send_item(rand_word_char(), 1'b0);
    endtask

    // ---------------- tests ----------------

    task automatic test_reset_defaults();
        send_text(" ab  cd");
        send_end();
        send_end();
        send_item(gww_pkg::C_SEP, 1'b0);
        send_item(gww_pkg::C_NUL, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(gww_pkg::C_NL, 1'b0);
        send_end();
    endtask

    task automatic test_long_words();
        write_line_length(6'd4);
        send_text("abcd ef abcdefghij");
        send_end();
    endtask

    task automatic test_length_clamp();
        write_line_length(6'd0);
        send_text("xyz");
        send_end();
        write_line_length(6'd63);
        send_text("qq");
        send_end();
        // a pending word is dropped by the register write
        send_text("zz");
        write_line_length(6'd33);
        send_end();
    endtask

    task automatic test_random_text();
        logic [gww_pkg::C_CFG_W-1:0] lens [6];
        int n, goal, r, len;
        lens = '{6'd1, 6'd63, 6'd32, 6'd33, 6'($urandom_range(2, 31)),
                 6'($urandom_range(2, 31))};
        foreach (lens[p]) begin
            write_line_length(lens[p]);
            n = line_width();
            tx_gaps_on   = (p != 2);
            rx_stalls_on = (p != 2);
            goal = text_items + PHASE_LEN;
            while (text_items < goal) begin
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    len = ($urandom_range(0, 4) == 0) ? $urandom_range(n + 1, 2 * n + 3)
                                                      : $urandom_range(1, n);
                    send_word(len);
                    repeat ($urandom_range(1, 3)) send_item(gww_pkg::C_SEP, 1'b0);
                end else if (r < 85) begin
                    send_end();
                end else if (r < 96) begin
                    send_item(8'($urandom_range(0, 255)), 1'b0);
                end else begin
                    wait_drained();
                end
            end
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        send_end();
    endtask

    initial begin
        load_line_length(gww_pkg::C_LL_RESET);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_long_words();
        test_length_clamp();
        test_random_text();

        wait_drained();
        if (err_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
